### design/pcpm_pkg.sv
// Package for the pseudocolour palette mapper: palette codes, colour type
// and the per-channel mapping functions. No dependencies.
`timescale 1ns / 1ps

package pcpm_pkg;

  localparam int PIX_W  = 8;
  localparam int MODE_W = 3;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [MODE_W-1:0] MODE_GRAY     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GRAY_INV = 3'd1;
  localparam logic [MODE_W-1:0] MODE_JET      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_JET_INV  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HOT      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_HOT_INV  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_HASH     = 3'd6;

  localparam logic REG_MODE = 1'b0;

  localparam logic [PIX_W-1:0] BAND3 = 8'd96;
  localparam logic [PIX_W-1:0] BAND5 = 8'd160;
  localparam logic [PIX_W-1:0] BAND7 = 8'd224;
  localparam logic [PIX_W-1:0] BAND1 = 8'd32;
  localparam logic [PIX_W-1:0] FULL  = 8'd255;
  localparam logic [PIX_W-1:0] HALF  = 8'd128;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } rgb_t;

  function automatic pix_t jet_ramp(input pix_t v);
    pix_t d;
    pix_t res;
    d = v - BAND3;
    if (v < BAND3) begin
      res = '0;
    end else if (v < BAND5) begin
      res = {d[5:0], 2'b00};
    end else if (v < BAND7) begin
      res = FULL;
    end else begin
      d = v - BAND7;
      res = FULL - {d[5:0], 2'b00};
    end
    return res;
  endfunction

  function automatic rgb_t jet_map(input pix_t p);
    pix_t tri_v;
    pix_t d;
    rgb_t c;
    tri_v = (p < HALF) ? p : (FULL - p);
    d = tri_v - BAND1;
    if (tri_v < BAND1) begin
      c.green = '0;
    end else if (tri_v < BAND3) begin
      c.green = {d[5:0], 2'b00};
    end else begin
      c.green = FULL;
    end
    c.blue = jet_ramp(FULL - p);
    c.red  = jet_ramp(p);
    return c;
  endfunction

  function automatic rgb_t hot_map(input pix_t p);
    rgb_t c;
    pix_t d;
    d = p - HALF;
    if (p < HALF) begin
      c.red   = {p[6:0], 1'b0};
      c.green = {p[6:0], 1'b0};
    end else begin
      c.red   = FULL;
      c.green = FULL - {d[6:0], 1'b0};
    end
    c.blue = '0;
    return c;
  endfunction

  function automatic rgb_t hash_map(input pix_t p);
    rgb_t c;
    pix_t q;
    pix_t h;
    pix_t neg;
    q = p - 8'd1;
    for (int k = 0; k < PIX_W; k++) begin
      h[k] = q[PIX_W-1-k];
    end
    neg = (~h) + 8'd1;
    if (p == '0) begin
      c = '0;
    end else begin
      c.blue  = h;
      c.red   = FULL - h;
      c.green = (h < HALF) ? {h[6:0], 1'b0} : {neg[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic rgb_t palette_map(input logic [MODE_W-1:0] mode, input pix_t p);
    rgb_t c;
    case (mode)
      MODE_GRAY:     c = '{red: p, green: p, blue: p};
      MODE_GRAY_INV: c = '{red: FULL - p, green: FULL - p, blue: FULL - p};
      MODE_JET:      c = jet_map(p);
      MODE_JET_INV:  c = jet_map(FULL - p);
      MODE_HOT:      c = hot_map(p);
      MODE_HOT_INV:  c = hot_map(FULL - p);
      MODE_HASH:     c = hash_map(p);
      default:       c = '0;
    endcase
    return c;
  endfunction

endpackage

### design/pcpm_regs.sv
// Configuration register file for the palette mapper: APB-style port,
// holds the palette mode. Depends on pcpm_pkg.
`timescale 1ns / 1ps

module pcpm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcpm_pkg::ADDR_W-1:0]   paddr,
  input  logic [pcpm_pkg::DATA_W-1:0]   pwdata,
  output logic [pcpm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [pcpm_pkg::MODE_W-1:0]   mode
);
  import pcpm_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_GRAY;
    end else if (wr_en) begin
      mode <= pwdata[MODE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1] == REG_MODE) begin
      prdata = {{(DATA_W-MODE_W){1'b0}}, mode};
    end
  end

endmodule

### design/pcpm_core.sv
// Two-register mapping pipe: pixel and mode captured on accept, colour
// computed and registered for the done strobe. Depends on pcpm_pkg.
`timescale 1ns / 1ps

module pcpm_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [pcpm_pkg::PIX_W-1:0]    pixel_level,
  input  logic [pcpm_pkg::MODE_W-1:0]   mode,
  output logic                          done,
  output pcpm_pkg::rgb_t                colour
);
  import pcpm_pkg::*;

  logic               in_valid;
  pix_t               pix_q;
  logic [MODE_W-1:0]  mode_q;
  rgb_t               colour_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= accept;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_q  <= pixel_level;
      mode_q <= mode;
    end
    if (in_valid) begin
      colour <= colour_next;
    end
  end

  assign colour_next = palette_map(mode_q, pix_q);

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> done)
    else $error("beat lost between stages");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_valid))
    else $error("done without a beat in the pipe");

  a_gray_equal: assert property (@(posedge clk) disable iff (rst)
    in_valid && (mode_q == MODE_GRAY || mode_q == MODE_GRAY_INV)
    |=> (colour.red == colour.green) && (colour.green == colour.blue))
    else $error("gray channels differ");

  a_hot_blue: assert property (@(posedge clk) disable iff (rst)
    in_valid && (mode_q == MODE_HOT || mode_q == MODE_HOT_INV) |=> colour.blue == '0)
    else $error("hot palette blue not zero");

  a_hash_pair: assert property (@(posedge clk) disable iff (rst)
    in_valid && (mode_q == MODE_HASH)
    |=> ((colour.red ^ colour.blue) == FULL)
        || ((colour.red | colour.green | colour.blue) == '0))
    else $error("hash palette red and blue not complementary");

endmodule

### design/pseudocolor_palette_map.sv
// Top level of the pseudocolour palette mapper: register port and mapping pipe.
// Depends on pcpm_pkg, pcpm_regs and pcpm_core.
`timescale 1ns / 1ps

// Takes one pixel every clock cycle; busy is never raised. Each pixel accepted
// with start gives one colour on red, green and blue through the input register
// and the result register around the combinational palette logic, marked by a
// one-cycle done pulse, in input order. The receiver cannot stall: a colour is
// held only until the next result replaces it.
// The palette mode is sampled with each pixel; mode 7 gives black.

module pseudocolor_palette_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcpm_pkg::ADDR_W-1:0]   paddr,
  input  logic [pcpm_pkg::DATA_W-1:0]   pwdata,
  output logic [pcpm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [pcpm_pkg::PIX_W-1:0]    pixel_level,
  output logic                          done,
  output logic [pcpm_pkg::PIX_W-1:0]    red,
  output logic [pcpm_pkg::PIX_W-1:0]    green,
  output logic [pcpm_pkg::PIX_W-1:0]    blue
);
  import pcpm_pkg::*;

  logic [MODE_W-1:0] mode;
  logic              accept;
  rgb_t              colour;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  pcpm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode    (mode)
  );

  pcpm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel_level (pixel_level),
    .mode        (mode),
    .done        (done),
    .colour      (colour)
  );

  assign red   = colour.red;
  assign green = colour.green;
  assign blue  = colour.blue;

endmodule

### tb/pcpm_colour_checker.sv
// Checker for the pseudocolour palette mapper: tracks the palette register,
// predicts the colour of every accepted pixel and compares each done beat.
// Depends on pcpm_pkg.
`timescale 1ns / 1ps

module pcpm_colour_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcpm_pkg::ADDR_W-1:0]   paddr,
  input  logic [pcpm_pkg::DATA_W-1:0]   pwdata,
  input  logic [pcpm_pkg::DATA_W-1:0]   prdata,
  input  logic                          pready,
  input  logic                          start,
  input  logic                          busy,
  input  pcpm_pkg::pix_t                pixel_level,
  input  logic                          done,
  input  pcpm_pkg::pix_t                red,
  input  pcpm_pkg::pix_t                green,
  input  pcpm_pkg::pix_t                blue,
  output int                            fail_count,
  output int                            pending
);
  import pcpm_pkg::*;

  localparam logic [ADDR_W-1:0] MODE_ADDR = ADDR_W'(4 * REG_MODE);

  typedef struct {
    pix_t level;
    rgb_t colour;
  } colour_due_t;

  colour_due_t       colours_due[$];
  logic [MODE_W-1:0] mode_copy = MODE_GRAY;

  function automatic pix_t band_ramp(input int v);
    int res;
    if (v < 3 * 32) res = 0;
    else if (v < 5 * 32) res = (v - 3 * 32) * 4;
    else if (v < 7 * 32) res = 255;
    else res = 255 - (v - 7 * 32) * 4;
    return pix_t'(res);
  endfunction

  function automatic rgb_t jet_colour(input int p);
    rgb_t c;
    int   tri_lvl;
    tri_lvl = (p < 128) ? p : 255 - p;
    if (tri_lvl < 32) c.green = '0;
    else if (tri_lvl < 3 * 32) c.green = pix_t'((tri_lvl - 32) * 4);
    else c.green = 8'd255;
    c.blue = band_ramp(255 - p);
    c.red  = band_ramp(p);
    return c;
  endfunction

  function automatic rgb_t hot_colour(input int p);
    rgb_t c;
    if (p < 128) begin
      c.red   = pix_t'(p * 2);
      c.green = pix_t'(p * 2);
    end else begin
      c.red   = 8'd255;
      c.green = pix_t'(255 - (p - 128) * 2);
    end
    c.blue = '0;
    return c;
  endfunction

  function automatic rgb_t hash_colour(input int p);
    rgb_t c;
    int   q;
    int   h;
    c = '0;
    if (p != 0) begin
      q = p - 1;
      h = 0;
      for (int k = 0; k < 8; k++) h = (h << 1) | ((q >> k) & 1);
      c.blue  = pix_t'(h);
      c.red   = pix_t'(255 - h);
      c.green = pix_t'((h < 128) ? h * 2 : (256 - h) * 2);
    end
    return c;
  endfunction

  function automatic rgb_t predict_colour(input logic [MODE_W-1:0] mode, input pix_t level);
    rgb_t c;
    int   p;
    p = int'(level);
    case (mode)
      MODE_GRAY:     c = '{red: level, green: level, blue: level};
      MODE_GRAY_INV: c = '{red: ~level, green: ~level, blue: ~level};
      MODE_JET:      c = jet_colour(p);
      MODE_JET_INV:  c = jet_colour(255 - p);
      MODE_HOT:      c = hot_colour(p);
      MODE_HOT_INV:  c = hot_colour(255 - p);
      MODE_HASH:     c = hash_colour(p);
      default:       c = '0;
    endcase
    return c;
  endfunction

  task automatic check_channel(input string chan, input pix_t level, input pix_t exp_v,
                               input pix_t act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      $display("%0t: %s mismatch for pixel %0d: expected %0d, actual %0d",
               $time, chan, level, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    colour_due_t head;
    if (rst) begin
      mode_copy = MODE_GRAY;
      colours_due.delete();
    end else begin
      if (done) begin
        if (colours_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected colour beat: expected none, actual r=%0d g=%0d b=%0d",
                   $time, red, green, blue);
        end else begin
          head = colours_due.pop_front();
          check_channel("red", head.level, head.colour.red, red);
          check_channel("green", head.level, head.colour.green, green);
          check_channel("blue", head.level, head.colour.blue, blue);
        end
      end
      if (psel && penable && pready && paddr == MODE_ADDR) begin
        if (pwrite) begin
          mode_copy = pwdata[MODE_W-1:0];
        end else if (prdata !== DATA_W'(mode_copy)) begin
          fail_count++;
          $display("%0t: mode readback mismatch: expected %0d, actual %0d",
                   $time, mode_copy, prdata);
        end
      end
      if (start && !busy) begin
        colours_due.push_back('{level: pixel_level,
                                colour: predict_colour(mode_copy, pixel_level)});
      end
    end
    pending = colours_due.size();
  end

endmodule

### tb/tb_pseudocolor_palette_map.sv
// Top of the pseudocolour palette mapper testbench: clock, reset, register
// writes and pixel stimulus with random gaps; verdict from pcpm_colour_checker.
// Depends on pcpm_pkg, pseudocolor_palette_map and pcpm_colour_checker.
`timescale 1ns / 1ps

module tb_pseudocolor_palette_map;
  import pcpm_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [ADDR_W-1:0] MODE_ADDR = ADDR_W'(4 * REG_MODE);

  localparam logic [MODE_W+PIX_W-1:0] DIRECTED [0:22] = '{
    {MODE_GRAY, 8'd0}, {MODE_GRAY, 8'd255}, {MODE_GRAY, 8'hAA}, {MODE_GRAY, 8'h55},
    {MODE_GRAY_INV, 8'd0}, {MODE_GRAY_INV, 8'd255},
    {MODE_JET, 8'd0}, {MODE_JET, 8'd96}, {MODE_JET, 8'd127}, {MODE_JET, 8'd128},
    {MODE_JET, 8'd255},
    {MODE_JET_INV, 8'd0}, {MODE_JET_INV, 8'd255},
    {MODE_HOT, 8'd0}, {MODE_HOT, 8'd127}, {MODE_HOT, 8'd128}, {MODE_HOT, 8'd255},
    {MODE_HOT_INV, 8'd0}, {MODE_HOT_INV, 8'd255},
    {MODE_HASH, 8'd0}, {MODE_HASH, 8'd1}, {MODE_HASH, 8'd2}, {MODE_HASH, 8'd255}
  };

  localparam pix_t BAND_EDGES [0:15] = '{
    8'd0, 8'd1, 8'd2, 8'd31, 8'd32, 8'd95, 8'd96, 8'd127,
    8'd128, 8'd129, 8'd159, 8'd160, 8'd223, 8'd224, 8'd254, 8'd255
  };

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              start;
  logic              busy;
  pix_t              pixel_level;
  logic              done;
  pix_t              red;
  pix_t              green;
  pix_t              blue;
  int                fail_count;
  int                pending;
  int                cycles = 0;

  pseudocolor_palette_map dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .pixel_level(pixel_level),
    .done(done), .red(red), .green(green), .blue(blue)
  );

  pcpm_colour_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .pixel_level(pixel_level),
    .done(done), .red(red), .green(green), .blue(blue),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic pix_t pick_level();
    if ($urandom_range(0, 5) == 0) return BAND_EDGES[$urandom_range(0, 15)];
    return pix_t'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input pix_t level);
    @(negedge clk);
    start = 1'b1;
    pixel_level = level;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      pixel_level = pix_t'($urandom);
    end
  endtask

  // hold off until every colour has come back, then let the pipe empty
  task automatic drain_colours();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [DATA_W-1:0] wdata);
    @(negedge clk);
    psel = 1'b1;
    pwrite = wr;
    paddr = MODE_ADDR;
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    pwdata = $urandom;
  endtask

  task automatic set_mode(input logic [MODE_W-1:0] mode);
    drain_colours();
    apb_access(1'b1, DATA_W'(mode));
    apb_access(1'b0, '0);
  endtask

  initial begin
    logic [MODE_W-1:0] mode;
    logic [MODE_W-1:0] last_mode;
    int                total;
    int                phase;
    int                len;
    bit                no_gaps;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    pixel_level = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    last_mode = MODE_GRAY;
    for (int i = 0; i <= 22; i++) begin
      mode = DIRECTED[i][MODE_W+PIX_W-1:PIX_W];
      if (i == 0 || mode != last_mode) set_mode(mode);
      last_mode = mode;
      send_pixel(DIRECTED[i][PIX_W-1:0]);
    end

    total = 0;
    phase = 0;
    while (total < RANDOM_ITEMS) begin
      if (phase == 0) mode = MODE_HASH;
      else if (phase == 1) mode = MODE_GRAY;
      else mode = MODE_W'($urandom_range(int'(MODE_GRAY), int'(MODE_HASH)));
      set_mode(mode);
      no_gaps = ($urandom_range(0, 3) == 0);
      len = $urandom_range(80, 240);
      if (len > RANDOM_ITEMS - total) len = RANDOM_ITEMS - total;
      for (int i = 0; i < len; i++) begin
        send_pixel(pick_level());
        total++;
        if (!no_gaps) idle_gap(gap_len());
      end
      phase++;
    end

    drain_colours();
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
design/pcpm_pkg.sv
design/pcpm_regs.sv
design/pcpm_core.sv
design/pseudocolor_palette_map.sv
tb/pcpm_colour_checker.sv
tb/tb_pseudocolor_palette_map.sv
